// ===== rtl/wes1d_pkg.sv =====
// Shared types and constants of the 1D wave equation stencil block.
// No dependencies; every other file of the block but wes1d_ram imports this package.
package wes1d_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int NPTS_W     = IDX_W + 1;
  localparam int VAL_W      = 32;
  localparam int STEPS_W    = 16;
  localparam int COUP_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COUP_W;

  // cycles between the last stencil read of a step and the buffer rotation
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING   = 2'd2;

  localparam logic [NPTS_W-1:0]  NPTS_RESET    = NPTS_W'(1024);
  localparam logic [STEPS_W-1:0] STEPS_RESET   = STEPS_W'(2);
  localparam logic [COUP_W-1:0]  COUPLING_RESET = COUP_W'(13107);
  localparam logic [NPTS_W-1:0]  NPTS_MIN      = NPTS_W'(3);
  localparam logic [NPTS_W-1:0]  NPTS_MAX      = NPTS_W'(MAX_POINTS);

  typedef struct packed {
    logic [1:0]              mode;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] old_value;
    logic signed [VAL_W-1:0] current_value;
  } in_item_t;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic              rd_en;
    logic              run_rd;
    logic [NPTS_W-1:0] rd_addr;
    logic              load_we;
    logic              rotate;
    logic              cap_read;
    logic              cap_done;
  } dp_cmd_t;

endpackage

// ===== rtl/wes1d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wes1d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wes1d_cfg.sv =====
// Configuration registers and the clamped point count.
// Depends on wes1d_pkg.
module wes1d_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wes1d_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wes1d_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [wes1d_pkg::NPTS_W-1:0]       npts_o,
  output logic [wes1d_pkg::STEPS_W-1:0]      num_steps_o,
  output logic [wes1d_pkg::COUP_W-1:0]       coupling_o
);
  import wes1d_pkg::*;

  logic [NPTS_W-1:0]  num_points_q;
  logic [STEPS_W-1:0] num_steps_q;
  logic [COUP_W-1:0]  coupling_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NPTS_RESET;
      num_steps_q  <= STEPS_RESET;
      coupling_q   <= COUPLING_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_POINTS: num_points_q <= cfg_data_i[NPTS_W-1:0];
        CFG_NUM_STEPS:  num_steps_q  <= cfg_data_i[STEPS_W-1:0];
        CFG_COUPLING:   coupling_q   <= cfg_data_i[COUP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the point count to the storage
  always_comb begin
    if (num_points_q < NPTS_MIN) begin
      npts_o = NPTS_MIN;
    end else if (num_points_q > NPTS_MAX) begin
      npts_o = NPTS_MAX;
    end else begin
      npts_o = num_points_q;
    end
  end

  assign num_steps_o = num_steps_q;
  assign coupling_o  = coupling_q;

endmodule

// ===== rtl/wes1d_ctrl.sv =====
// Controller: input handshake, step and address sequencing, result handshake.
// Depends on wes1d_pkg; drives the datapath through dp_cmd_t.
module wes1d_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_mode_i,
  input  logic [wes1d_pkg::IDX_W-1:0]   in_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [wes1d_pkg::NPTS_W-1:0]  npts_i,
  input  logic [wes1d_pkg::STEPS_W-1:0] num_steps_i,
  output wes1d_pkg::dp_cmd_t            cmd_o
);
  import wes1d_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [NPTS_W-1:0]  addr_q, addr_d;
  logic [STEPS_W-1:0] steps_q, steps_d;
  logic [DRAIN_W-1:0] drain_q, drain_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;
  logic               out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    steps_d = steps_q;
    drain_d = drain_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode_i)
            MODE_LOAD: cmd_o.load_we = 1'b1;
            MODE_READ: begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = {1'b0, in_index_i};
              state_d       = ST_READ;
            end
            MODE_RUN: begin
              addr_d  = '0;
              steps_d = num_steps_i - STEPS_W'(1);
              state_d = (num_steps_i < STEPS_W'(2)) ? ST_DONE : ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // read data sits in the RAM output register until the result slot frees
        if (out_free) begin
          cmd_o.cap_read = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        // one extra read past the last point lets the window reach it
        cmd_o.rd_en   = 1'b1;
        cmd_o.run_rd  = 1'b1;
        cmd_o.rd_addr = addr_q;
        addr_d        = addr_q + NPTS_W'(1);
        if (addr_q == npts_i) begin
          drain_d = DRAIN_W'(DRAIN_CYCLES - 1);
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q == '0) begin
          cmd_o.rotate = 1'b1;
          addr_d       = '0;
          steps_d      = steps_q - STEPS_W'(1);
          state_d      = (steps_q == STEPS_W'(1)) ? ST_DONE : ST_ISSUE;
        end else begin
          drain_d = drain_q - DRAIN_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.cap_done = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.cap_read || cmd_o.cap_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      steps_q     <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      steps_q     <= steps_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a capture never overwrites a result that is still waiting
  a_cap_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cap_read || cmd_o.cap_done) |-> out_free)
    else $error("result captured while output slot busy");

  // a step in progress always has at least one step left
  a_steps_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE || state_q == ST_DRAIN) |-> (steps_q != '0))
    else $error("step sequencing with no step left");

  // rotation happens only at the end of a drain
  a_rotate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rotate |-> (state_q == ST_DRAIN && drain_q == '0))
    else $error("buffer rotation outside drain end");

  // a run completion always follows a rotation or a run with no steps
  a_done_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DONE && state_d == ST_DONE) |->
      (cmd_o.rotate || (accept && in_mode_i == MODE_RUN)))
    else $error("run finished without stepping");

endmodule

// ===== rtl/wes1d_dpath.sv =====
// Datapath: three wave buffers, rotation, stencil pipeline and result register.
// Depends on wes1d_pkg and wes1d_ram.
module wes1d_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wes1d_pkg::dp_cmd_t            cmd_i,
  input  wes1d_pkg::in_item_t           in_data_i,
  input  logic [wes1d_pkg::NPTS_W-1:0]  npts_i,
  input  logic [wes1d_pkg::COUP_W-1:0]  coupling_i,
  output wes1d_pkg::out_item_t          out_data_o
);
  import wes1d_pkg::*;

  localparam int LAP_W  = VAL_W + 3;
  localparam int BASE_W = VAL_W + 2;
  localparam int PROD_W = LAP_W + COUP_W + 1;
  localparam int TERM_W = PROD_W - 16;
  localparam int SUM_W  = TERM_W + 1;

  logic [1:0] rot_q;
  logic [1:0] old_sel, cur_sel, nxt_sel;

  logic [2:0]           ram_we;
  logic [VAL_W-1:0]     ram_wdata [3];
  logic [VAL_W-1:0]     ram_rdata [3];
  logic [IDX_W-1:0]     waddr;
  logic signed [VAL_W-1:0] cur_rd, old_rd, run_wdata;

  // read pipeline
  logic              v1_q, oob_q;
  logic [NPTS_W-1:0] a1_q;
  logic signed [VAL_W-1:0] cm_q, cc_q, old_q;
  // stage A
  logic              va_q;
  logic [NPTS_W-1:0] pa_q;
  logic signed [LAP_W-1:0]  lap_q;
  logic signed [BASE_W-1:0] basea_q;
  // stage B
  logic              vb_q;
  logic [NPTS_W-1:0] pb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [BASE_W-1:0] baseb_q;
  // stage C
  logic              vc_q;
  logic [NPTS_W-1:0] pc_q;
  logic signed [TERM_W-1:0] term_q;
  logic signed [BASE_W-1:0] basec_q;

  logic signed [LAP_W-1:0]  lap_d;
  logic signed [BASE_W-1:0] base_d;
  logic signed [COUP_W:0]   coup_s;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SUM_W-1:0]  sum;
  logic                     boundary;

  out_item_t out_q;

  always_comb begin
    unique case (rot_q)
      2'd0:    begin old_sel = 2'd0; cur_sel = 2'd1; nxt_sel = 2'd2; end
      2'd1:    begin old_sel = 2'd1; cur_sel = 2'd2; nxt_sel = 2'd0; end
      default: begin old_sel = 2'd2; cur_sel = 2'd0; nxt_sel = 2'd1; end
    endcase
  end

  assign cur_rd = ram_rdata[cur_sel];
  assign old_rd = ram_rdata[old_sel];
  assign waddr  = cmd_i.load_we ? in_data_i.index : pc_q[IDX_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ram_we[k]    = 1'b0;
      ram_wdata[k] = run_wdata;
      if (cmd_i.load_we && k == int'(old_sel)) begin
        ram_we[k]    = 1'b1;
        ram_wdata[k] = in_data_i.old_value;
      end
      if (cmd_i.load_we && k == int'(cur_sel)) begin
        ram_we[k]    = 1'b1;
        ram_wdata[k] = in_data_i.current_value;
      end
      if (vc_q && k == int'(nxt_sel)) begin
        ram_we[k] = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_buf
    wes1d_ram #(
      .WIDTH(VAL_W),
      .DEPTH(MAX_POINTS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[g]),
      .waddr_i(waddr),
      .wdata_i(ram_wdata[g]),
      .re_i   (cmd_i.rd_en),
      .raddr_i(cmd_i.rd_addr[IDX_W-1:0]),
      .rdata_o(ram_rdata[g])
    );
  end

  // stencil arithmetic
  assign lap_d  = LAP_W'(cm_q) - (LAP_W'(cc_q) <<< 1) + LAP_W'(cur_rd);
  assign base_d = (BASE_W'(cc_q) <<< 1) - BASE_W'(old_q);
  assign coup_s = {1'b0, coupling_i};
  assign rnd    = prod_q + PROD_W'(32768);
  assign sum    = SUM_W'(basec_q) + SUM_W'(term_q);
  assign boundary = (pc_q == '0) || (pc_q == npts_i - NPTS_W'(1));

  always_comb begin
    if (boundary) begin
      run_wdata = '0;
    end else if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1) begin
      run_wdata = sum[VAL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      run_wdata = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      run_wdata = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= 2'd0;
      v1_q  <= 1'b0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
    end else begin
      if (cmd_i.rotate) begin
        rot_q <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
      end
      v1_q <= cmd_i.rd_en && cmd_i.run_rd;
      va_q <= v1_q && (a1_q != '0);
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= cmd_i.rd_addr;
    if (cmd_i.rd_en && !cmd_i.run_rd) begin
      oob_q <= ({1'b0, in_data_i.index} >= npts_i);
    end
    if (v1_q) begin
      // shift the three-point window and compute the point behind the newest read
      cm_q    <= cc_q;
      cc_q    <= cur_rd;
      old_q   <= old_rd;
      lap_q   <= lap_d;
      basea_q <= base_d;
      pa_q    <= a1_q - NPTS_W'(1);
    end
    prod_q  <= lap_q * coup_s;
    baseb_q <= basea_q;
    pb_q    <= pa_q;
    term_q  <= rnd[PROD_W-1:16];
    basec_q <= baseb_q;
    pc_q    <= pb_q;
    if (cmd_i.cap_read) begin
      out_q.kind  <= KIND_READ;
      out_q.value <= oob_q ? '0 : cur_rd;
    end else if (cmd_i.cap_done) begin
      out_q.kind  <= KIND_DONE;
      out_q.value <= '0;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/wave_equation_stencil_1d.sv =====
// 1D wave equation finite-difference stencil, Q16.16, top level.
// Depends on wes1d_pkg, wes1d_cfg, wes1d_ctrl, wes1d_dpath.
//
// Usage:
//  Input channel (in_valid_i / in_stall_o / in_data_i) carries load, run and
//  read transactions. Load writes the previous and current amplitude of one
//  point; loads are taken one per cycle while no read or run is in progress.
//  A read returns one point of the current wave. A run advances the wave by
//  num_steps-1 time steps (none when num_steps is below two) and then returns
//  a run-finished result; each step makes one stencil read of each point per
//  cycle from the current buffer, then drains the pipeline before rotating
//  the buffers. Mode 3 is taken and dropped.
//  Output channel (out_valid_o / out_stall_i / out_data_o) holds one result
//  in a register; while the receiver stalls, loads are still taken, and a
//  read or run waits for the slot before finishing.
//  Configuration (cfg_valid_i / cfg_ready_o) writes num_points, num_steps and
//  coupling while the block is idle, a rule for the user that the block does
//  not enforce; ready is always high. Reset clears control state and buffer
//  rotation, restores register defaults; buffers are undefined until loaded.
module wave_equation_stencil_1d (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  wes1d_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output wes1d_pkg::out_item_t             out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wes1d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wes1d_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wes1d_pkg::*;

  logic [NPTS_W-1:0]  npts;
  logic [STEPS_W-1:0] num_steps;
  logic [COUP_W-1:0]  coupling;
  dp_cmd_t            cmd;

  wes1d_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .npts_o     (npts),
    .num_steps_o(num_steps),
    .coupling_o (coupling)
  );

  wes1d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_mode_i  (in_data_i.mode),
    .in_index_i (in_data_i.index),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .npts_i     (npts),
    .num_steps_i(num_steps),
    .cmd_o      (cmd)
  );

  wes1d_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .npts_i    (npts),
    .coupling_i(coupling),
    .out_data_o(out_data_o)
  );

endmodule

// ===== sim/wes1d_checker.sv =====
// Checker for wave_equation_stencil_1d: keeps its own copy of the wave buffers and
// registers, predicts every result and compares it with what the block returns.
// Depends on wes1d_pkg for the payload types and the mode, kind and register codes.
module wes1d_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  wes1d_pkg::in_item_t              in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  wes1d_pkg::out_item_t             out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [wes1d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wes1d_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                               errors_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wes1d_pkg::*;

  localparam longint AMP_HI = 64'sd2147483647;
  localparam longint AMP_LO = -64'sd2147483648;

  // three rotating amplitude buffers: old = rot, current = rot+1, next = rot+2
  logic [VAL_W-1:0]   amp_mem [3][MAX_POINTS];
  int unsigned        rot;
  logic [NPTS_W-1:0]  npts_q;
  logic [STEPS_W-1:0] steps_q;
  logic [COUP_W-1:0]  coup_q;
  out_item_t          reply_q [$];
  int                 err_cnt;

  // One explicit time step over n points, then rotate the buffers.
  function automatic void wave_step(int unsigned n);
    int unsigned po, pc, pn, i;
    longint      ci, lap, term, sum;
    po = rot;
    pc = (rot + 1) % 3;
    pn = (rot + 2) % 3;
    amp_mem[pn][0]   = '0;
    amp_mem[pn][n-1] = '0;
    for (i = 1; i + 1 < n; i++) begin
      ci   = longint'($signed(amp_mem[pc][i]));
      lap  = longint'($signed(amp_mem[pc][i-1])) - 2 * ci
           + longint'($signed(amp_mem[pc][i+1]));
      // round half up to Q16.16
      term = (longint'(coup_q) * lap + 32768) >>> 16;
      sum  = 2 * ci - longint'($signed(amp_mem[po][i])) + term;
      if (sum > AMP_HI) sum = AMP_HI;
      if (sum < AMP_LO) sum = AMP_LO;
      amp_mem[pn][i] = sum[VAL_W-1:0];
    end
    rot = (rot + 1) % 3;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    int          t;
    out_item_t   want;
    if (!rst_ni) begin
      rot     = 0;
      npts_q  = NPTS_RESET;
      steps_q = STEPS_RESET;
      coup_q  = COUPLING_RESET;
      err_cnt = 0;
      reply_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // compare before predicting, so a result can never match an item taken this cycle
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          err_cnt++;
          $error("unexpected result: kind %0d value %0d", out_data_i.kind, out_data_i.value);
        end else begin
          want = reply_q.pop_front();
          if (out_data_i.kind !== want.kind) begin
            err_cnt++;
            $error("kind: expected %0d, got %0d", want.kind, out_data_i.kind);
          end
          if (out_data_i.value !== want.value) begin
            err_cnt++;
            $error("value: expected %0d, got %0d", want.value, out_data_i.value);
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NUM_POINTS: npts_q  = cfg_data_i[NPTS_W-1:0];
          CFG_NUM_STEPS:  steps_q = cfg_data_i[STEPS_W-1:0];
          CFG_COUPLING:   coup_q  = cfg_data_i[COUP_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        n = npts_q;
        if (npts_q > NPTS_MAX) n = MAX_POINTS;
        if (npts_q < NPTS_MIN) n = NPTS_MIN;
        case (in_data_i.mode)
          MODE_LOAD: begin
            amp_mem[rot][in_data_i.index]           = in_data_i.old_value;
            amp_mem[(rot + 1) % 3][in_data_i.index] = in_data_i.current_value;
          end
          MODE_RUN: begin
            for (t = 2; t <= int'(steps_q); t++) wave_step(n);
            want.kind  = KIND_DONE;
            want.value = '0;
            reply_q.push_back(want);
          end
          MODE_READ: begin
            want.kind  = KIND_READ;
            want.value = (in_data_i.index < n) ? amp_mem[(rot + 1) % 3][in_data_i.index] : '0;
            reply_q.push_back(want);
          end
          default: ;  // drop the unused mode
        endcase
      end

      errors_o  <= err_cnt;
      pending_o <= reply_q.size();
    end
  end

endmodule

// ===== sim/tb_wave_equation_stencil_1d.sv =====
// Testbench top for wave_equation_stencil_1d: clock, reset, stimulus and verdict.
// Depends on wes1d_pkg, the block's RTL and wes1d_checker, which does all checking.
module tb_wave_equation_stencil_1d;
  timeunit 1ns;
  timeprecision 1ps;

  import wes1d_pkg::*;

  localparam int          HALF_PERIOD   = 4;
  localparam int          RESET_CYCLES  = 12;
  localparam int          IDLE_PCT      = 14;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          ITEM_TARGET   = 1650;
  // longest correct quiet stretch is the max-step run on three points
  localparam int          STUCK_LIMIT   = 2000000;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned STEPS_TOP     = 65535;
  localparam int unsigned COUP_TOP      = 131071;
  localparam int unsigned NPTS_TOP      = 2047;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    err_count;
  int                    pending_count;

  bit          calm;       // no random idling on either side
  bit          hold_req;   // one long receiver hold-off
  bit          hold_done;  // set by the receiver once the hold-off has been served
  int          stuck_cycles = 0;

  // stimulus-side view: which buffer entries hold data, and the register values
  bit          filled [3][MAX_POINTS];
  int unsigned trot;
  int unsigned cfg_npts  = NPTS_RESET;
  int unsigned cfg_steps = STEPS_RESET;
  int unsigned cfg_coup  = COUPLING_RESET;
  int          item_count, n_loads, n_reads, n_runs, n_steps, n_settings;

  always #HALF_PERIOD clk = ~clk;

  wave_equation_stencil_1d DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wes1d_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (err_count),
    .pending_o   (pending_count)
  );

  // receiver: random stalls, or one counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("tb_wave_equation_stencil_1d: done, errors");
    $finish;
  end

  function automatic int unsigned wave_len();
    if (cfg_npts > MAX_POINTS) return MAX_POINTS;
    if (cfg_npts < NPTS_MIN) return NPTS_MIN;
    return cfg_npts;
  endfunction

  // mostly moderate amplitudes so runs do not pin at the rails, some full range
  function automatic logic [VAL_W-1:0] amp();
    int v;
    if ($urandom_range(99) < 30) return $urandom;
    v = int'($urandom_range(2097152)) - 1048576;
    return v;
  endfunction

  function automatic in_item_t junk_item(logic [1:0] mode);
    in_item_t it;
    it.mode          = mode;
    it.index         = IDX_W'($urandom);
    it.old_value     = $urandom;
    it.current_value = $urandom;
    return it;
  endfunction

  // Pick a read index whose current-buffer entry holds data, now and then an index beyond the wave.
  function automatic int unsigned read_idx();
    int unsigned n, k, j;
    n = wave_len();
    if (n < MAX_POINTS && $urandom_range(4) == 0) return $urandom_range(MAX_POINTS - 1, n);
    k = $urandom_range(n - 1);
    for (j = 0; j < n; j++)
      if (filled[(trot + 1) % 3][(k + j) % n]) return (k + j) % n;
    return n;
  endfunction

  task automatic offer(input in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.mode != MODE_UNUSED) item_count++;
  endtask

  task automatic load_pt(input int unsigned idx, input logic [VAL_W-1:0] ov, cv);
    in_item_t it;
    it.mode          = MODE_LOAD;
    it.index         = IDX_W'(idx);
    it.old_value     = ov;
    it.current_value = cv;
    offer(it);
    filled[trot][idx]           = 1'b1;
    filled[(trot + 1) % 3][idx] = 1'b1;
    n_loads++;
  endtask

  task automatic read_pt(input int unsigned idx);
    in_item_t it;
    it       = junk_item(MODE_READ);
    it.index = IDX_W'(idx);
    offer(it);
    n_reads++;
  endtask

  // Send a run only when every entry the stencil touches holds data.
  task automatic try_run();
    int unsigned n, i, t;
    n = wave_len();
    if (cfg_steps >= 2)
      for (i = 0; i < n; i++)
        if (!filled[(trot + 1) % 3][i] || (i > 0 && i + 1 < n && !filled[trot][i])) return;
    offer(junk_item(MODE_RUN));
    for (t = 2; t <= cfg_steps; t++) begin
      if (t < 5)
        for (i = 0; i < n; i++) filled[(trot + 2) % 3][i] = 1'b1;
      trot = (trot + 1) % 3;
      n_steps++;
    end
    n_runs++;
  endtask

  task automatic fill_wave();
    int unsigned order [MAX_POINTS];
    int unsigned n, j, tmp;
    int          i;
    n = wave_len();
    for (i = 0; i < n; i++) order[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < n; i++) load_pt(order[i], amp(), amp());
  endtask

  // Hold input idle until every result is back and the pipeline has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned npts, steps, coup);
    put_reg(CFG_NUM_POINTS, npts);
    put_reg(CFG_NUM_STEPS, steps);
    put_reg(CFG_COUPLING, coup);
    cfg_valid <= 1'b0;
    cfg_npts  = npts;
    cfg_steps = steps;
    cfg_coup  = coup;
    n_settings++;
  endtask

  initial begin
    int          p, i;
    int unsigned stop, roll, npts, steps, coup, n;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rails, the far index, the unused mode, an out-of-range read, then a run
    set_config(5, 3, COUPLING_RESET);
    load_pt(0, 32'h7fffffff, 32'h80000000);
    load_pt(1, 32'h80000000, 32'h7fffffff);
    load_pt(2, 32'h7fffffff, 32'h7fffffff);
    load_pt(3, 32'hffffffff, 32'h80000000);
    load_pt(4, 32'h00010000, 32'h00000000);
    load_pt(MAX_POINTS - 1, 32'h80000000, 32'h7fffffff);
    offer(junk_item(MODE_UNUSED));
    read_pt(MAX_POINTS - 1);
    read_pt(4);
    try_run();
    for (i = 0; i < 5; i++) read_pt(i);
    drain();

    // point count below the minimum, maximum steps, coupling above one
    set_config(0, STEPS_TOP, COUP_TOP);
    for (i = 0; i < 3; i++) load_pt(i, amp(), amp());
    try_run();
    read_pt(1);
    drain();

    // point count above the maximum with a single step: run only reports
    set_config(NPTS_TOP, 1, 0);
    try_run();
    read_pt(1);
    read_pt(4);
    drain();

    // one full-size wave
    set_config($urandom_range(1) ? MAX_POINTS : $urandom_range(NPTS_TOP, MAX_POINTS + 1),
               $urandom_range(3, 2), $urandom_range(COUP_TOP));
    fill_wave();
    try_run();
    for (i = 0; i < 8; i++) read_pt(read_idx());
    try_run();
    drain();

    p = 0;
    while (item_count < ITEM_TARGET) begin
      calm = (p == 4);
      roll = $urandom_range(9);
      npts = (roll == 0) ? $urandom_range(NPTS_MIN - 1) : $urandom_range(24, NPTS_MIN);
      roll = $urandom_range(9);
      steps = (roll < 2) ? $urandom_range(1) :
              (roll < 8) ? $urandom_range(6, 2) : $urandom_range(20, 7);
      case ($urandom_range(4))
        0:       coup = 0;
        1:       coup = 65536;
        2:       coup = COUPLING_RESET;
        3:       coup = $urandom_range(65536);
        default: coup = $urandom_range(COUP_TOP);
      endcase
      set_config(npts, steps, coup);
      n = wave_len();
      fill_wave();
      if (p == 2) begin
        // hold the output while reads pile up behind the result slot
        hold_req = 1'b1;
        repeat (16) read_pt(read_idx());
      end
      stop = item_count + $urandom_range(60, 20);
      while (item_count < stop) begin
        roll = $urandom_range(99);
        if (roll < 35)
          read_pt(read_idx());
        else if (roll < 50)
          try_run();
        else if (roll < 85)
          load_pt($urandom_range(n - 1), amp(), amp());
        else if (roll < 93)
          load_pt((n < MAX_POINTS) ? $urandom_range(MAX_POINTS - 1, n)
                                   : $urandom_range(MAX_POINTS - 1), amp(), amp());
        else
          offer(junk_item(MODE_UNUSED));
      end
      drain();
      p++;
    end
    calm = 1'b0;
    drain();

    $display("run covered %0d loads, %0d reads and %0d runs (%0d stencil steps)",
             n_loads, n_reads, n_runs, n_steps);
    $display("across %0d register settings, extremes of point count, steps and coupling",
             n_settings);
    if (err_count == 0 && pending_count == 0)
      $display("tb_wave_equation_stencil_1d: done, clean");
    else
      $display("tb_wave_equation_stencil_1d: done, errors");
    $finish;
  end

endmodule
